/* src/fpr_pkg.sv */
// fpr_pkg: shared types and field widths for the fifo page replacement block
// no dependencies
`default_nettype none

package fpr_pkg;

    // fixed widths of the access and result fields
    localparam int PAGE_FIELD_W  = 5;
    localparam int FRAME_FIELD_W = 4;

    // one resolved access, as it leaves the lookup logic
    typedef struct packed {
        logic [FRAME_FIELD_W-1:0] frame;
        logic                     hit;
        logic                     evicted_valid;
        logic [PAGE_FIELD_W-1:0]  evicted_page;
        logic                     writeback;
    } result_t;

endpackage

`default_nettype wire

/* src/fpr_core.sv */
// fpr_core: page table, frame owner table, dirty bits and fifo victim pointer
// resolves one access per cycle combinationally and updates the tables at the clock edge
// depends on fpr_pkg
`default_nettype none

module fpr_core #(
    parameter int NUM_PAGES  = 32,
    parameter int NUM_FRAMES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    input  logic [fpr_pkg::PAGE_FIELD_W-1:0]    page,
    input  logic                                is_write,
    output fpr_pkg::result_t                    res
);

    import fpr_pkg::*;

    localparam int PW       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FW       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PAGE_SPAN = 2 ** PAGE_FIELD_W;

    // page number folded into the table range, one constant entry per field value
    logic [PW-1:0] pg_lut [PAGE_SPAN];

    genvar gi;
    generate
        for (gi = 0; gi < PAGE_SPAN; gi++) begin : g_lut
            assign pg_lut[gi] = PW'(gi % NUM_PAGES);
        end
    endgenerate

    logic [NUM_PAGES-1:0]  present_reg;
    logic [FW-1:0]         frame_reg [NUM_PAGES];
    logic [PW-1:0]         owner_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] dirty_reg;
    logic [FW-1:0]         oldest_reg;
    logic                  full_reg;

    logic [PW-1:0]        pg;
    logic                 hit;
    logic [FW-1:0]        fr;
    logic [PW-1:0]        victim;
    logic                 evict;
    logic                 last_free;
    logic [FW-1:0]        oldest_next;
    logic [NUM_PAGES-1:0] present_next;

    always_comb
    begin
        pg          = pg_lut[page];
        hit         = present_reg[pg];
        fr          = hit ? frame_reg[pg] : oldest_reg;
        victim      = owner_reg[oldest_reg];
        evict       = !hit && full_reg;
        last_free   = ({1'b0, oldest_reg} + (FW+1)'(1)) >= (FW+1)'(NUM_FRAMES);
        oldest_next = last_free ? '0 : FW'(oldest_reg + FW'(1));

        // victim is resident and differs from the missing page
        present_next = present_reg;
        if (evict)
        begin
            present_next[victim] = 1'b0;
        end
        present_next[pg] = 1'b1;

        res.frame         = FRAME_FIELD_W'(fr);
        res.hit           = hit;
        res.evicted_valid = evict;
        res.evicted_page  = evict ? PAGE_FIELD_W'(victim) : '0;
        res.writeback     = evict && dirty_reg[oldest_reg];
    end

    // control state: present bits, dirty bits, fifo pointer, full flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            dirty_reg   <= '0;
            oldest_reg  <= '0;
            full_reg    <= 1'b0;
        end
        else if (valid)
        begin
            if (!hit)
            begin
                present_reg   <= present_next;
                dirty_reg[fr] <= is_write;
                oldest_reg    <= oldest_next;
                if (last_free)
                begin
                    full_reg <= 1'b1;
                end
            end
            else if (is_write)
            begin
                dirty_reg[fr] <= 1'b1;
            end
        end
    end

    // table payload, no reset
    always_ff @(posedge clk)
    begin
        if (valid && !hit)
        begin
            frame_reg[pg] <= fr;
            owner_reg[fr] <= pg;
        end
    end

endmodule

`default_nettype wire

/* src/fifo_page_replacement.sv */
// fifo_page_replacement: top level of the fifo page replacement block
// depends on fpr_pkg and fpr_core
`default_nettype none

// usage
//   command side: drive page and is_write with start high; the beat is taken
//   at any edge with start high and busy low. busy is always low here, so a
//   new access may be issued every cycle.
//   result side: done pulses for one cycle with frame, hit, evicted_valid,
//   evicted_page and writeback. the receiver cannot stall, so it must take
//   the result in that cycle.
//   each access passes through the input register, then the lookup logic
//   and the result register. throughput: one access per cycle, results in
//   issue order.
//   the table lookup and update for an access happen in the same cycle as its
//   result is registered, so back-to-back accesses see each other's updates.
//   reset: all pages absent, all frames clean, fill starts at frame 0;
//   no clearing pass is needed, the block is ready on the first cycle.
//   evicted_page and writeback read zero when nothing was evicted.
module fifo_page_replacement #(
    parameter int NUM_PAGES  = 32,
    parameter int NUM_FRAMES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [fpr_pkg::PAGE_FIELD_W-1:0]      page,
    input  logic                                  is_write,
    output logic                                  done,
    output logic [fpr_pkg::FRAME_FIELD_W-1:0]     frame,
    output logic                                  hit,
    output logic                                  evicted_valid,
    output logic [fpr_pkg::PAGE_FIELD_W-1:0]      evicted_page,
    output logic                                  writeback
);

    import fpr_pkg::*;

    // input register
    logic                    in_valid_reg;
    logic [PAGE_FIELD_W-1:0] in_page_reg;
    logic                    in_write_reg;

    // result register
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    // nothing ever holds the command side
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            res_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_page_reg  <= page;
            in_write_reg <= is_write;
        end
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // table lookup and fifo update
    fpr_core #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (in_valid_reg),
        .page     (in_page_reg),
        .is_write (in_write_reg),
        .res      (res_next)
    );

    assign done          = res_valid_reg;
    assign frame         = res_reg.frame;
    assign hit           = res_reg.hit;
    assign evicted_valid = res_reg.evicted_valid;
    assign evicted_page  = res_reg.evicted_page;
    assign writeback     = res_reg.writeback;

endmodule

`default_nettype wire
